FILE: hw/rtl/lexicographic_combination_generator_defines.svh
// Assertion macros used by the combination generator top module.
`ifndef LEXICOGRAPHIC_COMBINATION_GENERATOR_DEFINES_SVH
`define LEXICOGRAPHIC_COMBINATION_GENERATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lcg_pkg.sv
// Types, constants and codes shared by the combination generator modules.
package lcg_pkg;

    // Fixed field widths and default parameter values.
    localparam int ELEM_SLOTS           = 8;
    localparam int ELEM_W               = 8;
    localparam int K_W                  = 4;
    localparam int N_W                  = 8;
    localparam int CNT_W                = 7;
    localparam int CFG_IDX_W            = 2;
    localparam int CFG_DATA_W           = 8;
    localparam int MAX_SET_SIZE_DEFAULT = 8;
    localparam int INDEX_BITS_DEFAULT   = 8;
    localparam int MAX_BATCH_DEFAULT    = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CAND = 2'd1;

    // Command codes.
    localparam logic CMD_RESTART  = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Control handed from the sequencer to every cell.
    typedef struct packed {
        logic restart;
        logic step;
    } t_cell_ctl;

    // One input item.
    typedef struct packed {
        logic             command;
        logic [CNT_W-1:0] batch_count;
    } t_cmd_item;

    // One result item.
    typedef struct packed {
        logic [ELEM_W-1:0] elem0;
        logic [ELEM_W-1:0] elem1;
        logic [ELEM_W-1:0] elem2;
        logic [ELEM_W-1:0] elem3;
        logic [ELEM_W-1:0] elem4;
        logic [ELEM_W-1:0] elem5;
        logic [ELEM_W-1:0] elem6;
        logic [ELEM_W-1:0] elem7;
        logic              is_last;
        logic              exhausted;
    } t_result;

endpackage

FILE: hw/rtl/lcg_cell.sv
// One position of the combination: holds an index and computes its next value.
module lcg_cell #(
    parameter int POS        = 0,
    parameter int INDEX_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lcg_pkg::t_cell_ctl      i_ctl,
    input  logic                    i_active,
    input  logic [lcg_pkg::K_W-1:0] i_k,
    input  logic [lcg_pkg::N_W-1:0] i_n,
    input  logic                    i_found_right,
    output logic                    o_found_left,
    input  logic [INDEX_BITS-1:0]   i_left_val,
    input  logic                    i_left_chg,
    output logic [INDEX_BITS-1:0]   o_val,
    output logic                    o_chg,
    output logic [INDEX_BITS-1:0]   o_cur
);
    import lcg_pkg::*;

    localparam int CMP_W = ((INDEX_BITS > N_W) ? INDEX_BITS : N_W) + 2;

    logic [INDEX_BITS-1:0] r_idx;
    logic                  w_below;
    logic                  w_pivot;

    // The index can still grow while it sits below its bound n - k + POS.
    assign w_below = (CMP_W'(r_idx) + CMP_W'(i_k)) < (CMP_W'(i_n) + CMP_W'(POS));

    // The pivot is the rightmost active cell below its bound.
    assign w_pivot      = i_active && w_below && !i_found_right;
    assign o_found_left = i_found_right || (i_active && w_below);

    // The pivot increments; every active cell to its right refills consecutively.
    always_comb begin
        if (!i_active) begin
            o_val = r_idx;
        end else if (w_pivot) begin
            o_val = r_idx + INDEX_BITS'(1);
        end else if (i_left_chg) begin
            o_val = i_left_val + INDEX_BITS'(1);
        end else begin
            o_val = r_idx;
        end
    end

    assign o_chg = i_active && (w_pivot || i_left_chg);
    assign o_cur = r_idx;

    // Index register: restart loads the position itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_idx <= INDEX_BITS'(POS);
        end else if (i_ctl.step) begin
            r_idx <= o_val;
        end
    end

endmodule

FILE: hw/rtl/lexicographic_combination_generator.sv
// Lexicographic k-combination generator: a row of index cells under a batch sequencer.
//
// The block walks through every k-subset of {0..n-1} in lexicographic order, where k
// (set_size, 1..8) and n (num_candidates) are set through the write port; a write to
// either register restarts the walk at (0,1,..,k-1). A restart item gives no result. A
// generate item gives up to batch_count combinations, one per cycle while the output is
// taken, the last flagged is_last; the batch stops early on the final combination, and a
// generate item after that gives one item flagged exhausted. Each step is settled by a
// chain of eight cells: the search for the rightmost index below its bound runs right to
// left and the refill of the indices after it runs left to right, both combinationally.
// A generate item is accepted in idle, then its results are loaded one by one into the
// output register; a restart item is taken in idle and leaves the sequencer there.
// Input items are taken only between batches, while the output register lets the next
// command in as soon as the last result of a batch is loaded.
`include "lexicographic_combination_generator_defines.svh"

module lexicographic_combination_generator #(
    parameter int MAX_SET_SIZE = lcg_pkg::MAX_SET_SIZE_DEFAULT,
    parameter int INDEX_BITS   = lcg_pkg::INDEX_BITS_DEFAULT,
    parameter int MAX_BATCH    = lcg_pkg::MAX_BATCH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  lcg_pkg::t_cmd_item             i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output lcg_pkg::t_result               o_result
);
    import lcg_pkg::*;

    localparam int CMP_W = ((INDEX_BITS > N_W) ? INDEX_BITS : N_W) + 2;

    // Clamp the set size into 1..MAX_SET_SIZE.
    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] raw);
        logic [K_W-1:0] k;
        k = raw;
        if (k == '0) begin
            k = K_W'(1);
        end
        if (k > K_W'(MAX_SET_SIZE)) begin
            k = K_W'(MAX_SET_SIZE);
        end
        return k;
    endfunction

    t_state              r_state, n_state;
    logic [K_W-1:0]      r_set_size, n_set_size;
    logic [N_W-1:0]      r_num_cand, n_num_cand;
    logic [CNT_W-1:0]    r_remaining;
    logic                r_first_pending;
    logic                r_finished;
    logic                r_out_valid;
    t_result             r_out;

    logic [K_W-1:0]        w_k;
    logic [K_W-1:0]        w_k_next;
    logic                  w_accept;
    logic                  w_free;
    logic                  w_restart;
    logic                  w_generate;
    logic                  w_produce;
    logic                  w_final;
    logic                  w_is_last;
    logic                  w_live;
    logic [CNT_W-1:0]      w_count;
    t_cell_ctl             w_ctl;
    t_result               w_result;
    logic                  w_found [0:ELEM_SLOTS];
    logic [INDEX_BITS-1:0] w_val   [0:ELEM_SLOTS-1];
    logic                  w_chg   [0:ELEM_SLOTS-1];
    logic [INDEX_BITS-1:0] w_cur   [0:ELEM_SLOTS-1];
    logic [INDEX_BITS-1:0] w_emit  [0:ELEM_SLOTS-1];
    logic [ELEM_W-1:0]     w_elem  [0:ELEM_SLOTS-1];

    // Configuration registers and their values after this cycle's write.
    always_comb begin
        n_set_size = r_set_size;
        n_num_cand = r_num_cand;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SET_SIZE: n_set_size = i_cfg_data[K_W-1:0];
                REG_NUM_CAND: n_num_cand = i_cfg_data[N_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= K_W'(1);
            r_num_cand <= N_W'(1);
        end else begin
            r_set_size <= n_set_size;
            r_num_cand <= n_num_cand;
        end
    end

    assign w_k      = eff_k(r_set_size);
    assign w_k_next = eff_k(n_set_size);

    // Handshake and sequencer controls; writes to unused indexes leave the walk alone.
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_free     = !r_out_valid || i_ready;
    assign w_restart  = (i_cfg_we && ((i_cfg_idx == REG_SET_SIZE) || (i_cfg_idx == REG_NUM_CAND)))
                     || (w_accept && (i_item.command == CMD_RESTART));
    assign w_generate = w_accept && (i_item.command == CMD_GENERATE);
    assign w_produce  = (r_state == S_RUN) && w_free;

    assign w_ctl.restart = w_restart;
    assign w_ctl.step    = w_produce && !r_finished && !r_first_pending;

    // Row of index cells; the found flag ripples left, refill values ripple right.
    assign w_found[ELEM_SLOTS] = 1'b0;

    for (genvar p = 0; p < ELEM_SLOTS; p++) begin : g_cell
        logic [INDEX_BITS-1:0] w_left_val;
        logic                  w_left_chg;

        if (p == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_chg = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[p-1];
            assign w_left_chg = w_chg[p-1];
        end

        lcg_cell #(
            .POS        (p),
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_active      (K_W'(p) < w_k),
            .i_k           (w_k),
            .i_n           (r_num_cand),
            .i_found_right (w_found[p+1]),
            .o_found_left  (w_found[p]),
            .i_left_val    (w_left_val),
            .i_left_chg    (w_left_chg),
            .o_val         (w_val[p]),
            .o_chg         (w_chg[p]),
            .o_cur         (w_cur[p])
        );

        // The first combination is shown as held; later ones as advanced.
        assign w_emit[p] = r_first_pending ? w_cur[p] : w_val[p];
        assign w_elem[p] = (K_W'(p) < w_k) ? ELEM_W'(w_emit[p]) : '0;
    end

    // The emitted combination is the final one when its first index equals n - k.
    assign w_final   = (CMP_W'(w_emit[0]) + CMP_W'(w_k)) == CMP_W'(r_num_cand);
    assign w_is_last = r_finished || (r_remaining == CNT_W'(1)) || w_final;

    // Result item assembly.
    always_comb begin
        w_result.elem0     = r_finished ? '0 : w_elem[0];
        w_result.elem1     = r_finished ? '0 : w_elem[1];
        w_result.elem2     = r_finished ? '0 : w_elem[2];
        w_result.elem3     = r_finished ? '0 : w_elem[3];
        w_result.elem4     = r_finished ? '0 : w_elem[4];
        w_result.elem5     = r_finished ? '0 : w_elem[5];
        w_result.elem6     = r_finished ? '0 : w_elem[6];
        w_result.elem7     = r_finished ? '0 : w_elem[7];
        w_result.is_last   = w_is_last;
        w_result.exhausted = r_finished;
    end

    // Batch length with zero and overlarge requests clamped.
    always_comb begin
        w_count = i_item.batch_count;
        if (w_count == '0) begin
            w_count = CNT_W'(1);
        end
        if (w_count > CNT_W'(MAX_BATCH)) begin
            w_count = CNT_W'(MAX_BATCH);
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_generate) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_produce && w_is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Enumeration flags and the batch counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pending <= 1'b1;
            r_finished      <= 1'b0;
            r_remaining     <= '0;
        end else begin
            if (w_restart) begin
                r_first_pending <= 1'b1;
                r_finished      <= N_W'(w_k_next) > n_num_cand;
            end else if (w_produce && !r_finished) begin
                r_first_pending <= 1'b0;
                if (w_final) begin
                    r_finished <= 1'b1;
                end
            end
            if (w_generate) begin
                r_remaining <= w_count;
            end else if (w_produce) begin
                r_remaining <= r_remaining - CNT_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_out <= w_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_live = (r_state == S_RUN) && !r_finished && !r_first_pending;

    // A live enumeration past its first combination always has a pivot.
    `LCG_ASSERT_NOW(a_pivot_exists, w_live, w_found[0], "no pivot while enumeration is live")
    // A running batch always has results left to give.
    `LCG_ASSERT_NOW(a_batch_nonempty, r_state == S_RUN, r_remaining != '0, "empty batch running")
    // Loading the last result of a batch returns the sequencer to idle.
    `LCG_ASSERT_NEXT(a_last_ends_batch, w_produce && w_is_last, r_state == S_IDLE, "batch did not end")

endmodule
